[src/qvr_pkg.sv]
// Shared types and constants for the quaternion vector rotation block.
// Used by every module under src; depends on nothing else.
`timescale 1ns / 1ps

package qvr_pkg;

    // Component widths.
    localparam int COMP_W  = 16;                  // vector and quaternion components
    localparam int PROD1_W = 2 * COMP_W;          // q * v products
    localparam int A_W     = PROD1_W + 2;         // sums of three products
    localparam int PROD2_W = A_W + COMP_W;        // a * q products
    localparam int E_W     = PROD2_W + 2;         // sums of four products

    // Default fraction bits of the quaternion components (Q2.14).
    localparam int FRACTION_BITS = 14;

    // Configuration register map, word index = paddr[3:2].
    localparam int          ADDR_W    = 4;
    localparam logic [1:0]  REG_ROT_X = 2'd0;
    localparam logic [1:0]  REG_ROT_Y = 2'd1;
    localparam logic [1:0]  REG_ROT_Z = 2'd2;
    localparam logic [1:0]  REG_ROT_W = 2'd3;

    // rot_w resets to 16384, which is 1.0 at the default fraction width.
    localparam logic signed [COMP_W-1:0] ROT_W_RESET = 16'sd16384;

    // Saturation limits of a result component.
    localparam int OUT_MAX = 32767;
    localparam int OUT_MIN = -32768;

    typedef struct packed {
        logic signed [COMP_W-1:0] vec_x;
        logic signed [COMP_W-1:0] vec_y;
        logic signed [COMP_W-1:0] vec_z;
    } t_vec;

    typedef struct packed {
        logic signed [COMP_W-1:0] out_x;
        logic signed [COMP_W-1:0] out_y;
        logic signed [COMP_W-1:0] out_z;
        logic                     saturated;
    } t_res;

    typedef struct packed {
        logic signed [COMP_W-1:0] x;
        logic signed [COMP_W-1:0] y;
        logic signed [COMP_W-1:0] z;
        logic signed [COMP_W-1:0] w;
    } t_quat;

    // Intermediate quaternion a = q * (v, 0).
    typedef struct packed {
        logic signed [A_W-1:0] ax;
        logic signed [A_W-1:0] ay;
        logic signed [A_W-1:0] az;
        logic signed [A_W-1:0] aw;
    } t_avec;

    // Unscaled rotated vector.
    typedef struct packed {
        logic signed [E_W-1:0] ex;
        logic signed [E_W-1:0] ey;
        logic signed [E_W-1:0] ez;
    } t_evec;

endpackage

[src/qvr_cfg.sv]
// APB-style register file holding the rotation quaternion.
// Depends on qvr_pkg for the register map and the quaternion type.
`timescale 1ns / 1ps

module qvr_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [qvr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output qvr_pkg::t_quat            o_quat
);

    qvr_pkg::t_quat r_quat;
    qvr_pkg::t_quat n_quat;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_comb begin
        n_quat = r_quat;
        if (wr_en) begin
            case (reg_idx)
                qvr_pkg::REG_ROT_X: n_quat.x = pwdata[15:0];
                qvr_pkg::REG_ROT_Y: n_quat.y = pwdata[15:0];
                qvr_pkg::REG_ROT_Z: n_quat.z = pwdata[15:0];
                qvr_pkg::REG_ROT_W: n_quat.w = pwdata[15:0];
                default: n_quat = r_quat;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat.x <= '0;
            r_quat.y <= '0;
            r_quat.z <= '0;
            r_quat.w <= qvr_pkg::ROT_W_RESET;
        end else begin
            r_quat <= n_quat;
        end
    end

    always_comb begin
        case (reg_idx)
            qvr_pkg::REG_ROT_X: prdata = {16'd0, r_quat.x};
            qvr_pkg::REG_ROT_Y: prdata = {16'd0, r_quat.y};
            qvr_pkg::REG_ROT_Z: prdata = {16'd0, r_quat.z};
            qvr_pkg::REG_ROT_W: prdata = {16'd0, r_quat.w};
            default:            prdata = 32'd0;
        endcase
    end

    assign o_quat = r_quat;

    // A write to rot_w lands in the register on the next cycle.
    a_wr_w: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en && (reg_idx == qvr_pkg::REG_ROT_W) |=> r_quat.w == $past(pwdata[15:0]))
        else $error("rot_w write lost");

endmodule

[src/qvr_left_prod.sv]
// Two pipeline stages forming a = q * (v, 0): twelve products, then the sums.
// Depends on qvr_pkg for the vector, quaternion and intermediate types.
`timescale 1ns / 1ps

module qvr_left_prod (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  qvr_pkg::t_quat i_quat,
    input  logic           i_valid,
    input  qvr_pkg::t_vec  i_vec,
    output logic           o_ready,
    output logic           o_valid,
    output qvr_pkg::t_avec o_avec,
    input  logic           i_ready
);

    localparam int P1W = qvr_pkg::PROD1_W;
    localparam int AW  = qvr_pkg::A_W;

    logic signed [P1W-1:0] r_p [12];
    logic signed [P1W-1:0] n_p [12];
    logic                  r_va;
    logic                  r_vb;
    qvr_pkg::t_avec        r_avec;
    qvr_pkg::t_avec        n_avec;
    logic                  ready_a;
    logic                  ready_b;

    assign ready_b = !r_vb || i_ready;
    assign ready_a = !r_va || ready_b;
    assign o_ready = ready_a;

    always_comb begin
        n_p[0]  = P1W'(i_quat.w) * P1W'(i_vec.vec_x);
        n_p[1]  = P1W'(i_quat.y) * P1W'(i_vec.vec_z);
        n_p[2]  = P1W'(i_quat.z) * P1W'(i_vec.vec_y);
        n_p[3]  = P1W'(i_quat.w) * P1W'(i_vec.vec_y);
        n_p[4]  = P1W'(i_quat.x) * P1W'(i_vec.vec_z);
        n_p[5]  = P1W'(i_quat.z) * P1W'(i_vec.vec_x);
        n_p[6]  = P1W'(i_quat.w) * P1W'(i_vec.vec_z);
        n_p[7]  = P1W'(i_quat.x) * P1W'(i_vec.vec_y);
        n_p[8]  = P1W'(i_quat.y) * P1W'(i_vec.vec_x);
        n_p[9]  = P1W'(i_quat.x) * P1W'(i_vec.vec_x);
        n_p[10] = P1W'(i_quat.y) * P1W'(i_vec.vec_y);
        n_p[11] = P1W'(i_quat.z) * P1W'(i_vec.vec_z);
    end

    always_comb begin
        n_avec.ax = AW'(r_p[0]) + AW'(r_p[1]) - AW'(r_p[2]);
        n_avec.ay = AW'(r_p[3]) - AW'(r_p[4]) + AW'(r_p[5]);
        n_avec.az = AW'(r_p[6]) + AW'(r_p[7]) - AW'(r_p[8]);
        n_avec.aw = -AW'(r_p[9]) - AW'(r_p[10]) - AW'(r_p[11]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (ready_a) begin
                r_va <= i_valid;
            end
            if (ready_b) begin
                r_vb <= r_va;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_a && i_valid) begin
            r_p <= n_p;
        end
        if (ready_b && r_va) begin
            r_avec <= n_avec;
        end
    end

    assign o_valid = r_vb;
    assign o_avec  = r_avec;

endmodule

[src/qvr_right_prod.sv]
// Two pipeline stages forming the vector part of a * conj(q), unscaled.
// Depends on qvr_pkg for the quaternion and intermediate types.
`timescale 1ns / 1ps

module qvr_right_prod (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  qvr_pkg::t_quat i_quat,
    input  logic           i_valid,
    input  qvr_pkg::t_avec i_avec,
    output logic           o_ready,
    output logic           o_valid,
    output qvr_pkg::t_evec o_evec,
    input  logic           i_ready
);

    localparam int P2W = qvr_pkg::PROD2_W;
    localparam int EW  = qvr_pkg::E_W;

    logic signed [P2W-1:0] r_p [12];
    logic signed [P2W-1:0] n_p [12];
    logic                  r_va;
    logic                  r_vb;
    qvr_pkg::t_evec        r_evec;
    qvr_pkg::t_evec        n_evec;
    logic                  ready_a;
    logic                  ready_b;

    assign ready_b = !r_vb || i_ready;
    assign ready_a = !r_va || ready_b;
    assign o_ready = ready_a;

    always_comb begin
        n_p[0]  = P2W'(i_avec.aw) * P2W'(i_quat.x);
        n_p[1]  = P2W'(i_avec.ax) * P2W'(i_quat.w);
        n_p[2]  = P2W'(i_avec.ay) * P2W'(i_quat.z);
        n_p[3]  = P2W'(i_avec.az) * P2W'(i_quat.y);
        n_p[4]  = P2W'(i_avec.aw) * P2W'(i_quat.y);
        n_p[5]  = P2W'(i_avec.ax) * P2W'(i_quat.z);
        n_p[6]  = P2W'(i_avec.ay) * P2W'(i_quat.w);
        n_p[7]  = P2W'(i_avec.az) * P2W'(i_quat.x);
        n_p[8]  = P2W'(i_avec.aw) * P2W'(i_quat.z);
        n_p[9]  = P2W'(i_avec.ax) * P2W'(i_quat.y);
        n_p[10] = P2W'(i_avec.ay) * P2W'(i_quat.x);
        n_p[11] = P2W'(i_avec.az) * P2W'(i_quat.w);
    end

    always_comb begin
        n_evec.ex = -EW'(r_p[0]) + EW'(r_p[1]) - EW'(r_p[2]) + EW'(r_p[3]);
        n_evec.ey = -EW'(r_p[4]) + EW'(r_p[5]) + EW'(r_p[6]) - EW'(r_p[7]);
        n_evec.ez = -EW'(r_p[8]) - EW'(r_p[9]) + EW'(r_p[10]) + EW'(r_p[11]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (ready_a) begin
                r_va <= i_valid;
            end
            if (ready_b) begin
                r_vb <= r_va;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_a && i_valid) begin
            r_p <= n_p;
        end
        if (ready_b && r_va) begin
            r_evec <= n_evec;
        end
    end

    assign o_valid = r_vb;
    assign o_evec  = r_evec;

endmodule

[src/qvr_round_sat.sv]
// Output stage: scales by 2^-(2F) with round half up, saturates, registers result.
// Depends on qvr_pkg for the intermediate and result types.
`timescale 1ns / 1ps

module qvr_round_sat #(
    parameter int FRACTION_BITS = qvr_pkg::FRACTION_BITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  qvr_pkg::t_evec i_evec,
    output logic           o_ready,
    output logic           o_valid,
    output qvr_pkg::t_res  o_res,
    input  logic           i_ready
);

    localparam int SH = 2 * FRACTION_BITS;
    // Wide enough for the sum plus the rounding half without overflow.
    localparam int RW = (SH + 2 > qvr_pkg::E_W + 1) ? SH + 2 : qvr_pkg::E_W + 1;
    localparam logic signed [RW-1:0] HALF = RW'(1) << (SH - 1);
    localparam logic signed [RW-1:0] MAXV = RW'(qvr_pkg::OUT_MAX);
    localparam logic signed [RW-1:0] MINV = RW'(qvr_pkg::OUT_MIN);

    logic                 r_v;
    qvr_pkg::t_res        r_res;
    qvr_pkg::t_res        n_res;
    logic signed [RW-1:0] rnd_x;
    logic signed [RW-1:0] rnd_y;
    logic signed [RW-1:0] rnd_z;
    logic [2:0]           clip;

    assign o_ready = !r_v || i_ready;

    assign rnd_x = (RW'(i_evec.ex) + HALF) >>> SH;
    assign rnd_y = (RW'(i_evec.ey) + HALF) >>> SH;
    assign rnd_z = (RW'(i_evec.ez) + HALF) >>> SH;

    always_comb begin
        clip = 3'b000;
        n_res.out_x = rnd_x[15:0];
        n_res.out_y = rnd_y[15:0];
        n_res.out_z = rnd_z[15:0];
        if (rnd_x > MAXV) begin
            n_res.out_x = MAXV[15:0];
            clip[0] = 1'b1;
        end else if (rnd_x < MINV) begin
            n_res.out_x = MINV[15:0];
            clip[0] = 1'b1;
        end
        if (rnd_y > MAXV) begin
            n_res.out_y = MAXV[15:0];
            clip[1] = 1'b1;
        end else if (rnd_y < MINV) begin
            n_res.out_y = MINV[15:0];
            clip[1] = 1'b1;
        end
        if (rnd_z > MAXV) begin
            n_res.out_z = MAXV[15:0];
            clip[2] = 1'b1;
        end else if (rnd_z < MINV) begin
            n_res.out_z = MINV[15:0];
            clip[2] = 1'b1;
        end
        n_res.saturated = |clip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_v;
    assign o_res   = r_res;

    // The flag is only raised when some component sits at a rail.
    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v && r_res.saturated |->
            (r_res.out_x == MAXV[15:0]) || (r_res.out_x == MINV[15:0]) ||
            (r_res.out_y == MAXV[15:0]) || (r_res.out_y == MINV[15:0]) ||
            (r_res.out_z == MAXV[15:0]) || (r_res.out_z == MINV[15:0]))
        else $error("saturated flag without a clipped component");

endmodule

[src/quaternion_vector_rotate.sv]
// Five stages each hold one request; an accepted request passes through all of them.
// Throughput: one request per cycle while the output is not stalled.
// Stalls propagate back stage by stage, so bubbles are squeezed out and nothing repeats.
// Reset (synchronous, active low) empties the pipeline and sets the quaternion to
// identity at the default fraction width: x = y = z = 0, w = 16384.
`timescale 1ns / 1ps

module quaternion_vector_rotate #(
    parameter int FRACTION_BITS = qvr_pkg::FRACTION_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Configuration port.
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [qvr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    // Request channel.
    input  logic                       i_in_valid,
    input  qvr_pkg::t_vec              i_in_data,
    output logic                       o_in_stall,
    // Result channel.
    output logic                       o_out_valid,
    output qvr_pkg::t_res              o_out_data,
    input  logic                       i_out_stall
);

    // The datapath follows the Hamilton product form directly:
    //   stage 1: twelve 16x16 products of q and v,
    //   stage 2: sums giving a = q * (v, 0),
    //   stage 3: twelve 34x16 products of a and q,
    //   stage 4: sums giving the vector part of a * conj(q), exact,
    //   stage 5: round half up by 2^(2*FRACTION_BITS), saturate to 16 bits.
    // Each stage holds a valid bit and loads when it is empty or when the
    // stage after it is moving, so the stall path is a short ready chain.
    // The quaternion is read live from the register file; the user must rewrite it
    // only while the pipeline is empty; the block itself does not enforce this.

    qvr_pkg::t_quat quat;
    qvr_pkg::t_avec avec;
    qvr_pkg::t_evec evec;
    logic           left_ready;
    logic           left_valid;
    logic           right_ready;
    logic           right_valid;
    logic           out_ready;

    qvr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_quat  (quat)
    );

    qvr_left_prod u_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_quat  (quat),
        .i_valid (i_in_valid),
        .i_vec   (i_in_data),
        .o_ready (left_ready),
        .o_valid (left_valid),
        .o_avec  (avec),
        .i_ready (right_ready)
    );

    qvr_right_prod u_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_quat  (quat),
        .i_valid (left_valid),
        .i_avec  (avec),
        .o_ready (right_ready),
        .o_valid (right_valid),
        .o_evec  (evec),
        .i_ready (out_ready)
    );

    qvr_round_sat #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (right_valid),
        .i_evec  (evec),
        .o_ready (out_ready),
        .o_valid (o_out_valid),
        .o_res   (o_out_data),
        .i_ready (!i_out_stall)
    );

    // The input stalls only when every stage is full.
    assign o_in_stall = !left_ready;

    // A request can only be held off when a finished result is being held back.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while the output is free");

endmodule

[tb/qvr_rotation_checker.sv]
// Checker for the quaternion vector rotation block: it watches the register port and both
// streams, predicts every rotated vector, and compares results in order. Depends on qvr_pkg.
`timescale 1ns / 1ps

module qvr_rotation_checker
    import qvr_pkg::*;
#(
    parameter int FRACTION_BITS = qvr_pkg::FRACTION_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [31:0]       i_pwdata,
    input  logic              i_pready,
    input  logic              i_in_valid,
    input  t_vec              i_in_data,
    input  logic              i_in_stall,
    input  logic              i_out_valid,
    input  t_res              i_out_data,
    input  logic              i_out_stall,
    output int                o_mismatches,
    output int                o_pending,
    output int                o_rotations_checked,
    output int                o_clipped_results
);

    localparam int PRINT_LIMIT = 40;

    t_quat rotation = '{x: '0, y: '0, z: '0, w: ROT_W_RESET};
    t_res  expected_rotations [$];
    int    mismatch_count = 0;
    int    checked_count  = 0;
    int    clipped_count  = 0;

    assign o_mismatches        = mismatch_count;
    assign o_pending           = expected_rotations.size();
    assign o_rotations_checked = checked_count;
    assign o_clipped_results   = clipped_count;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("[%0t] MISMATCH: %s", $time, msg);
        end
    endtask

    // Scale by 2^-(2F), round half up, then clip to the 16-bit range.
    function automatic logic signed [COMP_W-1:0] round_clip(input longint e, inout logic hit);
        longint r;
        r = (e + (longint'(1) <<< (2 * FRACTION_BITS - 1))) >>> (2 * FRACTION_BITS);
        if (r > OUT_MAX) begin
            r   = OUT_MAX;
            hit = 1'b1;
        end
        if (r < OUT_MIN) begin
            r   = OUT_MIN;
            hit = 1'b1;
        end
        return r[COMP_W-1:0];
    endfunction

    // Vector part of q * (v, 0) * conj(q), kept exact in 64 bits until the final scaling.
    function automatic t_res rotate_vector(input t_quat q, input t_vec v);
        longint qx, qy, qz, qw, vx, vy, vz;
        longint ax, ay, az, aw, rx, ry, rz;
        logic   hit;
        t_res   res;
        qx = $signed(q.x);
        qy = $signed(q.y);
        qz = $signed(q.z);
        qw = $signed(q.w);
        vx = $signed(v.vec_x);
        vy = $signed(v.vec_y);
        vz = $signed(v.vec_z);
        ax = qw * vx + qy * vz - qz * vy;
        ay = qw * vy - qx * vz + qz * vx;
        az = qw * vz + qx * vy - qy * vx;
        aw = -qx * vx - qy * vy - qz * vz;
        rx = -aw * qx + ax * qw - ay * qz + az * qy;
        ry = -aw * qy + ax * qz + ay * qw - az * qx;
        rz = -aw * qz - ax * qy + ay * qx + az * qw;
        hit = 1'b0;
        res.out_x     = round_clip(rx, hit);
        res.out_y     = round_clip(ry, hit);
        res.out_z     = round_clip(rz, hit);
        res.saturated = hit;
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_res want;
        if (!i_rst_n) begin
            rotation = '{x: '0, y: '0, z: '0, w: ROT_W_RESET};
            expected_rotations.delete();
        end else begin
            // Results first: a request taken at this edge cannot complete at the same edge.
            if (i_out_valid && !i_out_stall) begin
                if (expected_rotations.size() == 0) begin
                    report_mismatch($sformatf("result %p arrived with no request pending",
                                              i_out_data));
                end else begin
                    want = expected_rotations.pop_front();
                    if (i_out_data.out_x !== want.out_x)
                        report_mismatch($sformatf("out_x got %0d, want %0d",
                                                  i_out_data.out_x, want.out_x));
                    if (i_out_data.out_y !== want.out_y)
                        report_mismatch($sformatf("out_y got %0d, want %0d",
                                                  i_out_data.out_y, want.out_y));
                    if (i_out_data.out_z !== want.out_z)
                        report_mismatch($sformatf("out_z got %0d, want %0d",
                                                  i_out_data.out_z, want.out_z));
                    if (i_out_data.saturated !== want.saturated)
                        report_mismatch($sformatf("saturated got %b, want %b",
                                                  i_out_data.saturated, want.saturated));
                    checked_count++;
                    if (want.saturated) clipped_count++;
                end
            end
            // Requests use the quaternion in force before any write at this same edge.
            if (i_in_valid && !i_in_stall) begin
                expected_rotations.push_back(rotate_vector(rotation, i_in_data));
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_ROT_X: rotation.x = i_pwdata[COMP_W-1:0];
                    REG_ROT_Y: rotation.y = i_pwdata[COMP_W-1:0];
                    REG_ROT_Z: rotation.z = i_pwdata[COMP_W-1:0];
                    REG_ROT_W: rotation.w = i_pwdata[COMP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

[tb/quaternion_vector_rotate_test.sv]
// Top of the quaternion vector rotation testbench: clock, reset, register writes and vector
// stimulus, plus the verdict. Depends on qvr_pkg, the block and qvr_rotation_checker.
`timescale 1ns / 1ps

module quaternion_vector_rotate_test;
    import qvr_pkg::*;

    // The block's pipeline is five deep; the drain idles for DRAIN_CYCLES after the last result.
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_REQUESTS = 300;

    // Kinds of quaternion used for the random phases.
    typedef enum int {ROT_SMALL, ROT_FULL, ROT_NEAR_IDENTITY} rot_kind_t;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [ADDR_W-1:0] paddr       = '0;
    logic [31:0]       pwdata      = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              i_in_valid  = 1'b0;
    t_vec              i_in_data   = '0;
    logic              o_in_stall;
    logic              o_out_valid;
    t_res              o_out_data;
    logic              i_out_stall = 1'b0;

    int mismatch_count;
    int pending_count;
    int rotations_checked;
    int clipped_results;

    // When idle_on is low both sides run flat out, giving stretches with no gaps at all.
    bit idle_on       = 1'b1;
    int vectors_sent  = 0;
    int settings_used = 0;
    int stall_hold    = 0;

    quaternion_vector_rotate u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    qvr_rotation_checker u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_psel              (psel),
        .i_penable           (penable),
        .i_pwrite            (pwrite),
        .i_paddr             (paddr),
        .i_pwdata            (pwdata),
        .i_pready            (pready),
        .i_in_valid          (i_in_valid),
        .i_in_data           (i_in_data),
        .i_in_stall          (o_in_stall),
        .i_out_valid         (o_out_valid),
        .i_out_data          (o_out_data),
        .i_out_stall         (i_out_stall),
        .o_mismatches        (mismatch_count),
        .o_pending           (pending_count),
        .o_rotations_checked (rotations_checked),
        .o_clipped_results   (clipped_results)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // The run can never legitimately take this long: even if every request met the longest
    // gap and the longest output stall it would finish well inside a third of this time.
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Length of one idle stretch, drawn from a short range most of the time and from a long range now and then.
    function automatic int idle_length();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // The result side alternates runs of readiness with stalls of random length. All changes
    // happen at the falling edge, so the block sees a settled stall at every rising edge.
    always @(negedge i_clk) begin
        if (!idle_on) begin
            i_out_stall = 1'b0;
            stall_hold  = 0;
        end else if (stall_hold > 0) begin
            stall_hold--;
        end else if (i_out_stall || $urandom_range(0, 2) != 0) begin
            i_out_stall = 1'b0;
            stall_hold  = $urandom_range(0, 6);
        end else begin
            i_out_stall = 1'b1;
            stall_hold  = idle_length() - 1;
        end
    end

    function automatic t_vec make_vec(input int x, input int y, input int z);
        t_vec v;
        v.vec_x = x[COMP_W-1:0];
        v.vec_y = y[COMP_W-1:0];
        v.vec_z = z[COMP_W-1:0];
        return v;
    endfunction

    function automatic t_quat make_quat(input int x, input int y, input int z, input int w);
        t_quat q;
        q.x = x[COMP_W-1:0];
        q.y = y[COMP_W-1:0];
        q.z = z[COMP_W-1:0];
        q.w = w[COMP_W-1:0];
        return q;
    endfunction

    // One component drawn from the 16-bit range limits, zero and its neighbors.
    function automatic int corner_value();
        case ($urandom_range(0, 4))
            0: return 32767;
            1: return -32768;
            2: return 0;
            3: return 1;
            default: return -1;
        endcase
    endfunction

    // Random vectors: mostly full 16-bit patterns, so every bit toggles, with small values
    // that stay clear of clipping and corner values mixed in.
    function automatic t_vec random_vector();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) return t_vec'({16'($urandom), 16'($urandom), 16'($urandom)});
        if (pick < 9) return make_vec(int'($urandom_range(0, 600)) - 300,
                                      int'($urandom_range(0, 600)) - 300,
                                      int'($urandom_range(0, 600)) - 300);
        return make_vec(corner_value(), corner_value(), corner_value());
    endfunction

    // Small components keep the squared norm near or below one, so few results clip; full
    // random quaternions scale by up to sixteen and clip most of the time.
    function automatic t_quat random_rotation(input rot_kind_t kind);
        case (kind)
            ROT_FULL: return t_quat'({$urandom, $urandom});
            ROT_NEAR_IDENTITY:
                return make_quat(int'($urandom_range(0, 4000)) - 2000,
                                 int'($urandom_range(0, 4000)) - 2000,
                                 int'($urandom_range(0, 4000)) - 2000,
                                 int'($urandom_range(14000, 16384)));
            default:
                return make_quat(int'($urandom_range(0, 18000)) - 9000,
                                 int'($urandom_range(0, 18000)) - 9000,
                                 int'($urandom_range(0, 18000)) - 9000,
                                 int'($urandom_range(0, 18000)) - 9000);
        endcase
    endfunction

    // One register write: a setup cycle, then an access cycle held until pready.
    task automatic write_register(input logic [1:0] index, input logic [COMP_W-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {index, 2'b00};
        pwdata  = {{(32 - COMP_W){value[COMP_W-1]}}, value};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic write_rotation(input t_quat q);
        write_register(REG_ROT_X, q.x);
        write_register(REG_ROT_Y, q.y);
        write_register(REG_ROT_Z, q.z);
        write_register(REG_ROT_W, q.w);
        settings_used++;
    endtask

    // Stop sending and wait for every outstanding request to come back, then let the
    // pipeline settle. Registers are only rewritten after this.
    task automatic drain_pipeline();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Present one request and hold it steady until the block takes it. After a zero gap the
    // next call raises valid again at the very next falling edge, so valid simply stays high.
    task automatic send_vector(input t_vec v);
        int gap;
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_data  = v;
        do @(posedge i_clk); while (o_in_stall);
        vectors_sent++;
        gap = (idle_on && $urandom_range(0, 99) < 35) ? idle_length() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    initial begin : stimulus
        rot_kind_t phase_kind [RANDOM_PHASES];
        int        p;
        int        n;
        phase_kind = '{ROT_SMALL, ROT_FULL, ROT_SMALL, ROT_NEAR_IDENTITY, ROT_FULL, ROT_SMALL};

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset quaternion is the identity, so vectors, including the extremes, pass through.
        send_vector(make_vec(0, 0, 0));
        send_vector(make_vec(32767, 32767, 32767));
        send_vector(make_vec(-32768, -32768, -32768));
        send_vector(make_vec(32767, -32768, 1));
        send_vector(make_vec(21845, -21846, -1));
        send_vector(make_vec(-1, 0, 12345));
        drain_pipeline();

        // A pure w of one half scales by a quarter: odd multiples of two land exactly on a
        // half and must round upward on both signs.
        write_rotation(make_quat(0, 0, 0, 8192));
        send_vector(make_vec(2, -2, 6));
        send_vector(make_vec(-6, 1, -1));
        send_vector(make_vec(3, -3, 5));
        send_vector(make_vec(32767, -32768, 4));
        drain_pipeline();

        // Unnormalized extremes: every component at the top, then every one at the bottom.
        // Both scale by about sixteen, so large vectors clip in both directions.
        write_rotation(make_quat(32767, 32767, 32767, 32767));
        send_vector(make_vec(1, 0, 0));
        send_vector(make_vec(32767, -32768, 100));
        send_vector(make_vec(0, -1, 0));
        drain_pipeline();
        write_rotation(make_quat(-32768, -32768, -32768, -32768));
        send_vector(make_vec(-32768, 32767, -100));
        send_vector(make_vec(5, 7, -9));
        send_vector(make_vec(32767, 32767, 32767));
        drain_pipeline();

        // A zero quaternion collapses every vector to the origin.
        write_rotation(make_quat(0, 0, 0, 0));
        send_vector(make_vec(12345, -32768, 32767));
        drain_pipeline();

        // A quarter turn about z swaps x into y.
        write_rotation(make_quat(0, 0, 11585, 11585));
        send_vector(make_vec(1000, 0, 0));
        send_vector(make_vec(0, 32767, 0));
        send_vector(make_vec(-32768, -32768, -32768));
        drain_pipeline();

        // Random phases, each under a fresh quaternion. Phase two runs with no idling on
        // either side, and phase one also stops halfway until everything has come back.
        for (p = 0; p < RANDOM_PHASES; p++) begin
            idle_on = (p != 2);
            write_rotation(random_rotation(phase_kind[p]));
            for (n = 0; n < PHASE_REQUESTS; n++) begin
                if (p == 1 && n == PHASE_REQUESTS / 2) drain_pipeline();
                send_vector(random_vector());
            end
            drain_pipeline();
        end

        idle_on = 1'b1;
        $display("Summary: %0d vectors rotated under %0d written quaternions plus the reset one,",
                 vectors_sent, settings_used);
        $display("Summary: %0d results compared, %0d of them clipped, %0d mismatches.",
                 rotations_checked, clipped_results, mismatch_count);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
